### rtl/ois_pkg.sv
package ois_pkg;

    localparam int UNIVERSE_SIZE = 1024;
    localparam int KEY_W         = 10;
    localparam int WORD_W        = 32;
    localparam int BIT_W         = $clog2(WORD_W);
    localparam int WORD_CNT      = UNIVERSE_SIZE / WORD_W;
    localparam int WADDR_W       = $clog2(WORD_CNT);

    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [WADDR_W-1:0]  waddr_t;
    typedef logic [BIT_W-1:0]    bidx_t;
    typedef logic [WORD_CNT-1:0] summary_t;

    typedef enum logic [2:0] {
        FUNC_INSERT = 3'd0,
        FUNC_DELETE = 3'd1,
        FUNC_MIN    = 3'd2,
        FUNC_MAX    = 3'd3,
        FUNC_PRED   = 3'd4,
        FUNC_SUCC   = 3'd5,
        FUNC_MEMBER = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL1,
        ST_EVAL2,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic   en;
        waddr_t addr;
        word_t  data;
    } mem_wr_t;

    typedef struct packed {
        logic   en;
        waddr_t addr;
    } mem_rd_t;

endpackage

### rtl/ois_word_mem.sv
module ois_word_mem #(
    parameter int ADDR_W = ois_pkg::WADDR_W,
    parameter int DATA_W = ois_pkg::WORD_W
) (
    input  logic                aclk,
    input  ois_pkg::mem_wr_t    wr,
    input  ois_pkg::mem_rd_t    rd,
    output logic [DATA_W-1:0]   rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

### rtl/ois_find.sv
module ois_find #(
    parameter int W     = ois_pkg::WORD_W,
    parameter int IDX_W = ois_pkg::BIT_W
) (
    input  logic [W-1:0]     vec,
    input  logic [W-1:0]     mask,
    input  logic             up,
    output logic             found,
    output logic [IDX_W-1:0] idx
);

    logic [W-1:0] masked;

    // up: lowest set bit; otherwise highest set bit
    always_comb begin
        masked = vec & mask;
        found  = |masked;
        idx    = '0;
        if (up) begin
            for (int i = W - 1; i >= 0; i--) begin
                if (masked[i]) begin
                    idx = IDX_W'(i);
                end
            end
        end else begin
            for (int i = 0; i < W; i++) begin
                if (masked[i]) begin
                    idx = IDX_W'(i);
                end
            end
        end
    end

endmodule

### rtl/ordered_integer_set.sv
// Ordered integer set over the values 0 .. 1023.
//
// Input channel (s_valid / s_ready, s_func, s_key): one transfer carries an
// operation and a key. Insert and delete update the set and return nothing.
// Min, max, strict predecessor, strict successor and member each return one
// transfer on the result channel (m_valid / m_ready, m_found, m_answer);
// m_answer is 0 whenever m_found is 0. Code 7 is taken and dropped.
//
// The set lives in a 32 x 32-bit word memory with a registered
// read, plus a 32-bit summary register that marks non-empty words. A word
// whose summary bit is clear reads as zero, so no memory clearing is needed.
//
// Steps per item, limited by the single read port of the word memory:
//   insert, delete              : read, then modify and write back
//   code 7                      : read, then dropped with no write
//   member, min, max            : read, evaluate, then load the result register
//   predecessor, successor      : read and evaluate, a second read when the answer
//                                 lies in another word, then load the result register
// One item is worked on at a time; s_ready is high only while idle.
//
// Reset (aresetn low, synchronous) empties the set and drops any pending
// result. A stalled receiver holds the result in the output register; the
// next item is still taken and finishes up to its result, then waits.
module ordered_integer_set (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_func,
    input  ois_pkg::key_t        s_key,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_found,
    output ois_pkg::key_t        m_answer
);

    ois_pkg::state_t   state_reg, state_next;
    ois_pkg::func_t    func_reg, func_next;
    ois_pkg::key_t     key_reg, key_next;
    ois_pkg::waddr_t   waddr_reg, waddr_next;
    ois_pkg::summary_t sum_reg, sum_next;
    logic              sum_hit_reg, sum_hit_next;
    logic              res_found_reg, res_found_next;
    ois_pkg::key_t     res_answer_reg, res_answer_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_found_reg, m_found_next;
    ois_pkg::key_t     m_answer_reg, m_answer_next;

    ois_pkg::mem_wr_t  wr;
    ois_pkg::mem_rd_t  rd;
    ois_pkg::word_t    rd_data;
    ois_pkg::word_t    rd_word;
    ois_pkg::word_t    new_word;
    ois_pkg::word_t    key_onehot;
    ois_pkg::word_t    w_below;
    ois_pkg::word_t    w_above;
    ois_pkg::summary_t s_below;
    ois_pkg::summary_t s_above;

    ois_pkg::waddr_t   key_word;
    ois_pkg::bidx_t    key_bit;

    ois_pkg::summary_t sf_mask;
    logic              sf_up;
    logic              sf_found;
    ois_pkg::waddr_t   sf_idx;
    ois_pkg::word_t    wf_mask;
    logic              wf_up;
    logic              wf_found;
    ois_pkg::bidx_t    wf_idx;

    ois_word_mem #(
        .ADDR_W (ois_pkg::WADDR_W),
        .DATA_W (ois_pkg::WORD_W)
    ) u_word_mem (
        .aclk    (aclk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    // Search over the summary: which word holds the next candidate
    ois_find #(
        .W     (ois_pkg::WORD_CNT),
        .IDX_W (ois_pkg::WADDR_W)
    ) u_sum_find (
        .vec   (sum_reg),
        .mask  (sf_mask),
        .up    (sf_up),
        .found (sf_found),
        .idx   (sf_idx)
    );

    // Search inside the word just read
    ois_find #(
        .W     (ois_pkg::WORD_W),
        .IDX_W (ois_pkg::BIT_W)
    ) u_word_find (
        .vec   (rd_word),
        .mask  (wf_mask),
        .up    (wf_up),
        .found (wf_found),
        .idx   (wf_idx)
    );

    assign key_word = key_reg[ois_pkg::KEY_W-1:ois_pkg::BIT_W];
    assign key_bit  = key_reg[ois_pkg::BIT_W-1:0];

    // Words never written since reset have a clear summary bit: read them as empty
    assign rd_word = sum_reg[waddr_reg] ? rd_data : '0;

    assign key_onehot = ois_pkg::word_t'(1) << key_bit;
    assign w_below    = key_onehot - ois_pkg::word_t'(1);
    assign w_above    = ~(w_below | key_onehot);
    assign s_below    = (ois_pkg::summary_t'(1) << key_word) - ois_pkg::summary_t'(1);
    assign s_above    = ~(s_below | (ois_pkg::summary_t'(1) << key_word));

    assign s_ready  = (state_reg == ois_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_found  = m_found_reg;
    assign m_answer = m_answer_reg;

    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        waddr_next      = waddr_reg;
        sum_next        = sum_reg;
        sum_hit_next    = sum_hit_reg;
        res_found_next  = res_found_reg;
        res_answer_next = res_answer_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_found_next    = m_found_reg;
        m_answer_next   = m_answer_reg;
        new_word        = '0;
        wr              = '0;
        rd.en           = 1'b0;
        rd.addr         = s_key[ois_pkg::KEY_W-1:ois_pkg::BIT_W];
        sf_mask         = '1;
        sf_up           = 1'b1;
        wf_mask         = '1;
        wf_up           = 1'b1;

        unique case (state_reg)
            ois_pkg::ST_IDLE: begin
                // min and max locate their word from the summary right away
                sf_up = (s_func == ois_pkg::FUNC_MIN);
                if (s_valid) begin
                    func_next    = ois_pkg::func_t'(s_func);
                    key_next     = s_key;
                    sum_hit_next = sf_found;
                    rd.en        = 1'b1;
                    if (s_func == ois_pkg::FUNC_MIN || s_func == ois_pkg::FUNC_MAX) begin
                        rd.addr = sf_idx;
                    end
                    waddr_next = rd.addr;
                    state_next = ois_pkg::ST_EVAL1;
                end
            end

            ois_pkg::ST_EVAL1: begin
                wf_up = (func_reg == ois_pkg::FUNC_MIN) || (func_reg == ois_pkg::FUNC_SUCC);
                sf_up = (func_reg == ois_pkg::FUNC_SUCC);
                if (func_reg == ois_pkg::FUNC_PRED) begin
                    wf_mask = w_below;
                    sf_mask = s_below;
                end else if (func_reg == ois_pkg::FUNC_SUCC) begin
                    wf_mask = w_above;
                    sf_mask = s_above;
                end
                state_next = ois_pkg::ST_RESULT;

                unique case (func_reg)
                    ois_pkg::FUNC_INSERT: begin
                        new_word           = rd_word | key_onehot;
                        wr                 = '{en: 1'b1, addr: key_word, data: new_word};
                        sum_next[key_word] = 1'b1;
                        state_next         = ois_pkg::ST_IDLE;
                    end
                    ois_pkg::FUNC_DELETE: begin
                        new_word           = rd_word & ~key_onehot;
                        wr                 = '{en: 1'b1, addr: key_word, data: new_word};
                        sum_next[key_word] = |new_word;
                        state_next         = ois_pkg::ST_IDLE;
                    end
                    ois_pkg::FUNC_MEMBER: begin
                        res_found_next  = rd_word[key_bit];
                        res_answer_next = rd_word[key_bit] ? key_reg : '0;
                    end
                    ois_pkg::FUNC_MIN, ois_pkg::FUNC_MAX: begin
                        res_found_next  = sum_hit_reg;
                        res_answer_next = sum_hit_reg ? {waddr_reg, wf_idx} : '0;
                    end
                    ois_pkg::FUNC_PRED, ois_pkg::FUNC_SUCC: begin
                        if (wf_found) begin
                            res_found_next  = 1'b1;
                            res_answer_next = {key_word, wf_idx};
                        end else if (sf_found) begin
                            // answer sits in another word: fetch it
                            rd.en      = 1'b1;
                            rd.addr    = sf_idx;
                            waddr_next = sf_idx;
                            state_next = ois_pkg::ST_EVAL2;
                        end else begin
                            res_found_next  = 1'b0;
                            res_answer_next = '0;
                        end
                    end
                    default: begin
                        state_next = ois_pkg::ST_IDLE;
                    end
                endcase
            end

            ois_pkg::ST_EVAL2: begin
                // word is non-empty by the summary; take its nearest end
                wf_up           = (func_reg == ois_pkg::FUNC_SUCC);
                res_found_next  = 1'b1;
                res_answer_next = {waddr_reg, wf_idx};
                state_next      = ois_pkg::ST_RESULT;
            end

            ois_pkg::ST_RESULT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_found_next  = res_found_reg;
                    m_answer_next = res_answer_reg;
                    state_next    = ois_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = ois_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ois_pkg::ST_IDLE;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        waddr_reg      <= waddr_next;
        sum_hit_reg    <= sum_hit_next;
        res_found_reg  <= res_found_next;
        res_answer_reg <= res_answer_next;
        m_found_reg    <= m_found_next;
        m_answer_reg   <= m_answer_next;
    end

endmodule

### rtl/ois_checker.sv
module ois_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input logic          m_found,
    input ois_pkg::key_t m_answer
);

    // one item at a time: busy right after a transfer is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a transfer");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_answer))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_answer == '0)
        else $error("answer not zero on a miss");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

endmodule

bind ordered_integer_set ois_checker u_ois_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_found  (m_found),
    .m_answer (m_answer)
);
